// ===== src/image_header_crc_checker_assert.svh =====
// Assertion macros shared by the image header CRC checker modules.
`ifndef IMAGE_HEADER_CRC_CHECKER_ASSERT_SVH
`define IMAGE_HEADER_CRC_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define IHCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ihcc: assertion failed");
`define IHCC_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`else
`define IHCC_ASSERT(lbl, prop)
`define IHCC_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

// ===== src/ihcc_pkg.sv =====
// Types, constants and CRC step functions for the image header CRC checker.
package ihcc_pkg;

  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [7:0]  HDR_BYTE0 = 8'h18;
  localparam logic [7:0]  HDR_BYTEN = 8'h00;
  localparam int          HDR_LEN   = 4;

  localparam logic [31:0] NIB_TABLE [16] = '{
    32'h0000_0000, 32'h1DB7_1064, 32'h3B6E_20C8, 32'h26D9_30AC,
    32'h76DC_4190, 32'h6B6B_51F4, 32'h4DB2_6158, 32'h5005_713C,
    32'hEDB8_8320, 32'hF00F_9344, 32'hD6D6_A3E8, 32'hCB61_B38C,
    32'h9B64_C2B0, 32'h86D3_D2D4, 32'hA00A_E278, 32'hBDBD_F21C
  };

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_BAD_HDR = 2'd2,
    ST_CRC_BAD = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] crc_value;
  } result_t;

  function automatic logic [31:0] crc_nibble(input logic [31:0] crc, input logic [3:0] nib);
    return NIB_TABLE[crc[3:0] ^ nib] ^ (crc >> 4);
  endfunction

  // low nibble first, then high nibble
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    return crc_nibble(crc_nibble(crc, b[3:0]), b[7:4]);
  endfunction

endpackage

// ===== src/ihcc_in_if.sv =====
// Input request channel: one image byte with its last marker.
interface ihcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/ihcc_out_if.sv =====
// Result request channel: status and final CRC of one image.
interface ihcc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] crc_value;

  modport source (output valid, output status, output crc_value, input ready);
  modport sink   (input valid, input status, input crc_value, output ready);
endinterface

// ===== src/image_header_crc_checker.sv =====
// Top level: input register, result register and expected-CRC register.
//
// Usage:
//   in_ch carries one image byte per request (data_byte, last_byte); out_ch
//   carries one request per image (status, crc_value), produced only for the
//   byte marked last. Both channels move a request when valid and ready are
//   high at a rising edge of clk.
//   cfg_we/cfg_wdata write crc_expected (zero turns the CRC compare off);
//   write it only while no image is in flight.
//   Path: a last byte moves from the input register into the result register,
//   which drives out_ch; it waits in the input register while that is full.
//   Throughput: one byte per cycle unless a last byte waits on a held result;
//   the input register feeds the running CRC through two table nibble steps.
//   Reset (rst_n low, synchronous) empties both registers, sets the CRC to
//   all ones, clears the byte count and crc_expected.
//   A stalled receiver holds the result; one more last byte can wait in the
//   input register and in_ch.ready drops only then. Non-last bytes keep
//   flowing while a result waits.
`include "image_header_crc_checker_assert.svh"
module image_header_crc_checker
  import ihcc_pkg::*;
#(
  parameter int MIN_LENGTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  ihcc_in_if.sink       in_ch,
  ihcc_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);

  logic        s1_valid_r, s1_valid_nxt;
  byte_req_t   s1_req_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r;
  logic [31:0] crc_exp_r;

  logic        s1_adv;
  logic        in_take;
  result_t     core_res;

  ihcc_core #(
    .MIN_LENGTH (MIN_LENGTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (s1_adv),
    .req          (s1_req_r),
    .crc_expected (crc_exp_r),
    .result       (core_res)
  );

  always_comb begin
    s1_adv   = s1_valid_r && (!s1_req_r.last_byte || !out_valid_r || out_ch.ready);
    in_ch.ready = !s1_valid_r || s1_adv;
    in_take  = in_ch.valid && in_ch.ready;

    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_req_r.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    out_ch.valid     = out_valid_r;
    out_ch.status    = out_res_r.status;
    out_ch.crc_value = out_res_r.crc_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_exp_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        crc_exp_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r.data_byte <= in_ch.data_byte;
      s1_req_r.last_byte <= in_ch.last_byte;
    end
    if (s1_adv && s1_req_r.last_byte) begin
      out_res_r <= core_res;
    end
  end

  `IHCC_ASSERT(a_result_loads, (s1_valid_r && s1_req_r.last_byte && !out_valid_r) |=> out_valid_r)
  `IHCC_ASSERT_MSG(a_stall_cause, !in_ch.ready |-> (s1_valid_r && s1_req_r.last_byte && out_valid_r && !out_ch.ready), "ihcc: input stalled without a blocked result")
  `IHCC_ASSERT(a_no_drop, (out_valid_r && !out_ch.ready) |=> out_valid_r)

endmodule

// ===== src/ihcc_core.sv =====
// Per-image state (running CRC, byte count, header flag) and result logic.
`include "image_header_crc_checker_assert.svh"
module ihcc_core
  import ihcc_pkg::*;
#(
  parameter int MIN_LENGTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  byte_req_t   req,
  input  logic [31:0] crc_expected,
  output result_t     result
);

  localparam int CNT_W = $clog2(MIN_LENGTH + 1);

  logic [31:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;

  logic [31:0]      crc_step;
  logic [CNT_W-1:0] count_step;
  logic             hdr_ok_step;
  logic [7:0]       want;

  always_comb begin
    want        = (count_r == '0) ? HDR_BYTE0 : HDR_BYTEN;
    crc_step    = crc_byte(crc_r, req.data_byte);
    hdr_ok_step = hdr_ok_r &
                  ((count_r >= CNT_W'(HDR_LEN)) || (req.data_byte == want));
    count_step  = (count_r < CNT_W'(MIN_LENGTH)) ? count_r + CNT_W'(1) : count_r;

    result.crc_value = ~crc_step;
    if (count_step < CNT_W'(MIN_LENGTH)) begin
      result.status = ST_SHORT;
    end else if (!hdr_ok_step) begin
      result.status = ST_BAD_HDR;
    end else if ((crc_expected != '0) && (~crc_step != crc_expected)) begin
      result.status = ST_CRC_BAD;
    end else begin
      result.status = ST_OK;
    end

    crc_nxt    = crc_r;
    count_nxt  = count_r;
    hdr_ok_nxt = hdr_ok_r;
    if (advance) begin
      if (req.last_byte) begin
        crc_nxt    = CRC_INIT;
        count_nxt  = '0;
        hdr_ok_nxt = 1'b1;
      end else begin
        crc_nxt    = crc_step;
        count_nxt  = count_step;
        hdr_ok_nxt = hdr_ok_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      count_r  <= '0;
      hdr_ok_r <= 1'b1;
    end else begin
      crc_r    <= crc_nxt;
      count_r  <= count_nxt;
      hdr_ok_r <= hdr_ok_nxt;
    end
  end

  `IHCC_ASSERT(a_count_sat, count_r <= CNT_W'(MIN_LENGTH))
  `IHCC_ASSERT_MSG(a_image_clear, (advance && req.last_byte) |=> (count_r == '0 && crc_r == CRC_INIT && hdr_ok_r), "ihcc: state not cleared after last byte")
  `IHCC_ASSERT(a_hold_idle, !advance |=> ($stable(crc_r) && $stable(count_r)))

endmodule

// ===== test/image_header_crc_checker_tb.sv =====
// Testbench for image_header_crc_checker: streams images and checks status and CRC per image.
`timescale 1ns / 100ps

module image_header_crc_checker_tb
  import ihcc_pkg::*;
();

  localparam int          MIN_LEN     = 8;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam int          STALL_LIMIT = 2000;
  localparam int          PHASE_BYTES = 160;

  typedef logic [7:0] octet_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  ihcc_in_if  in_bus();
  ihcc_out_if out_bus();

  image_header_crc_checker #(
    .MIN_LENGTH(MIN_LEN)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  byte_req_t stream_q[$];
  result_t   expected_reports[$];
  octet_t    img_buf[$];
  octet_t    golden_img[$];
  logic [31:0] golden_crc;

  // image tracking state
  logic [31:0] img_crc;
  logic [3:0]  img_len;
  logic        img_hdr_ok;
  logic [31:0] crc_expect_reg;

  int  send_idle_pct;
  int  recv_stall_pct;
  int  err_count;
  int  idle_run;
  bit  in_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // bit-serial reflected CRC-32, LSB first
  function automatic logic [31:0] crc32_add_byte(input logic [31:0] crc, input octet_t b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic absorb_byte(input byte_req_t r);
    result_t want;
    if (img_len < HDR_LEN) begin
      if (r.data_byte != ((img_len == 0) ? HDR_BYTE0 : HDR_BYTEN)) img_hdr_ok = 1'b0;
    end
    img_crc = crc32_add_byte(img_crc, r.data_byte);
    if (img_len < MIN_LEN) img_len = img_len + 4'd1;
    if (r.last_byte) begin
      want.crc_value = ~img_crc;
      if (img_len < MIN_LEN) want.status = ST_SHORT;
      else if (!img_hdr_ok) want.status = ST_BAD_HDR;
      else if (crc_expect_reg != 0 && want.crc_value != crc_expect_reg) want.status = ST_CRC_BAD;
      else want.status = ST_OK;
      expected_reports.push_back(want);
      img_crc    = CRC_INIT;
      img_len    = '0;
      img_hdr_ok = 1'b1;
    end
  endtask

  // driver
  always @(negedge clk) begin
    logic hold;
    hold = in_bus.valid && !in_taken;
    in_taken = 1'b0;
    if (!hold && rst_n && stream_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_bus.data_byte <= stream_q[0].data_byte;
      in_bus.last_byte <= stream_q[0].last_byte;
      void'(stream_q.pop_front());
      hold = 1'b1;
    end
    in_bus.valid  <= hold;
    out_bus.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    result_t want;
    byte_req_t req;
    bit moved;
    if (!rst_n) begin
      img_crc        = CRC_INIT;
      img_len        = '0;
      img_hdr_ok     = 1'b1;
      crc_expect_reg = '0;
      in_taken       = 1'b0;
      idle_run       = 0;
    end else begin
      moved = 1'b0;
      if (out_bus.valid && out_bus.ready) begin
        moved = 1'b1;
        if (expected_reports.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected request: status %0d crc %08h", out_bus.status, out_bus.crc_value);
        end else begin
          want = expected_reports.pop_front();
          if (out_bus.status !== want.status || out_bus.crc_value !== want.crc_value) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: status exp %0d got %0d, crc exp %08h got %08h",
                       want.status, out_bus.status, want.crc_value, out_bus.crc_value);
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        moved = 1'b1;
        req.data_byte = in_bus.data_byte;
        req.last_byte = in_bus.last_byte;
        absorb_byte(req);
        in_taken = 1'b1;
      end
      idle_run = moved ? 0 : idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic queue_image();
    byte_req_t r;
    for (int i = 0; i < img_buf.size(); i++) begin
      r.data_byte = img_buf[i];
      r.last_byte = (i == img_buf.size() - 1);
      stream_q.push_back(r);
    end
  endtask

  task automatic write_crc_expected(input logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    crc_expect_reg = v;
  endtask

  task automatic wait_drained();
    while (stream_q.size() != 0 || in_bus.valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic build_random_image();
    int kind;
    int n;
    int pos;
    kind = $urandom_range(99);
    img_buf.delete();
    if (kind < 25) begin
      img_buf = golden_img;
    end else if (kind < 90) begin
      img_buf = '{HDR_BYTE0, HDR_BYTEN, HDR_BYTEN, HDR_BYTEN};
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 16);
      repeat (n) img_buf.push_back(octet_t'($urandom));
      if (kind >= 75) begin
        pos = $urandom_range(3);
        img_buf[pos] = img_buf[pos] ^ octet_t'($urandom_range(1, 255));
      end
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) img_buf.push_back(octet_t'($urandom));
    end
  endtask

  task automatic make_golden();
    int n;
    golden_img = '{HDR_BYTE0, HDR_BYTEN, HDR_BYTEN, HDR_BYTEN};
    n = $urandom_range(4, 8);
    repeat (n) golden_img.push_back(octet_t'($urandom));
    golden_crc = CRC_INIT;
    foreach (golden_img[i]) golden_crc = crc32_add_byte(golden_crc, golden_img[i]);
    golden_crc = ~golden_crc;
  endtask

  initial begin
    int sent;
    logic [31:0] cfg_val;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    in_bus.last_byte = 1'b0;
    out_bus.ready    = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    err_count        = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: short, good, bad header, then CRC compare enabled
    write_crc_expected(32'h0);
    img_buf = '{8'hFF};
    queue_image();
    img_buf = '{8'h18, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hA5, 8'h5A};
    golden_img = img_buf;
    queue_image();
    img_buf = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78};
    queue_image();
    wait_drained();
    golden_crc = CRC_INIT;
    foreach (golden_img[i]) golden_crc = crc32_add_byte(golden_crc, golden_img[i]);
    write_crc_expected(~golden_crc);
    img_buf = golden_img;
    queue_image();
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      make_golden();
      case (p)
        1:       cfg_val = 32'hFFFF_FFFF;
        2, 6:    cfg_val = 32'h0;
        5:       cfg_val = $urandom;
        default: cfg_val = golden_crc;
      endcase
      write_crc_expected(cfg_val);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_random_image();
        sent += img_buf.size();
        queue_image();
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0 && expected_reports.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ihcc_pkg.sv
src/ihcc_in_if.sv
src/ihcc_out_if.sv
src/ihcc_core.sv
src/image_header_crc_checker.sv
test/image_header_crc_checker_tb.sv
